// ----- rtl/hv2d_pkg.sv -----
// Shared types and constants for the 2-D hypervolume sweep block.
// Used by hypervolume_2d_sweep_top.
package hv2d_pkg;

    localparam int MaxPoints = 1024;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = $clog2(MaxPoints + 1);

    localparam logic [1:0] RegRefX = 2'd0;
    localparam logic [1:0] RegRefY = 2'd1;
    localparam logic [1:0] RegSort = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_SW_RD,
        ST_SW_WAIT,
        ST_SW_MUL,
        ST_SW_ACC,
        ST_LAST_MUL,
        ST_LAST_ACC,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/hv2d_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module hv2d_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/hypervolume_2d_sweep_top.sv -----
// 2-D hypervolume sweep: points stream into one sort-key RAM (y in high half), one per cycle
// while in_stall is low. After the last item, an in-place insertion sort runs (when enabled),
// then the sweep walks the points through the single RAM port and a registered multiplier.
// A finished result waits in its own output register.
// Reset (rst_n, async low) clears state, config, count, ovf and out_valid only; not the RAM.
// Depends on hv2d_pkg and hv2d_ram.
module hypervolume_2d_sweep_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [31:0]             point_x,
    input  logic signed [31:0]             point_y,
    input  logic                           point_present,
    input  logic                           last_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [63:0]             volume,
    output logic [hv2d_pkg::CountW-1:0]    point_count,
    output logic                           saturated,
    output logic                           dropped
);
    localparam int AW = hv2d_pkg::AddrW;
    localparam int CW = hv2d_pkg::CountW;

    hv2d_pkg::state_t state_reg, state_next;
    logic [31:0] ref_x_reg, ref_y_reg;
    logic        sort_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] prev_reg, prev_next;     // key of previous point / sort fetch flag
    logic signed [33:0] w_reg, w_next;
    logic signed [33:0] dy_reg, dy_next;
    logic signed [67:0] prod_reg, prod_next;
    logic signed [79:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic signed [63:0] vol_reg, vol_next;
    logic [CW-1:0] pc_reg, pc_next;
    logic        sat_reg, sat_next, drop_reg, drop_next;
    logic signed [63:0] res_vol_reg, res_vol_next;
    logic [CW-1:0] res_pc_reg, res_pc_next;
    logic        res_sat_reg, res_sat_next, res_drop_reg, res_drop_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [63:0]   ram_wdata, ram_rdata;

    hv2d_ram #(.Width(64), .Depth(hv2d_pkg::MaxPoints)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    wire in_xfer  = in_valid && !in_stall;
    wire out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != hv2d_pkg::ST_LOAD);

    function automatic logic signed [33:0] ky(input logic [63:0] k);
        ky = 34'(signed'(k[63:32] ^ 32'h8000_0000));
    endfunction
    function automatic logic signed [33:0] dx(input logic [31:0] rx, input logic [63:0] k);
        dx = 34'(signed'(rx)) - 34'(signed'(k[31:0]));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hv2d_pkg::ST_LOAD;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            sort_reg      <= 1'b1;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hv2d_pkg::RegRefX: ref_x_reg <= cfg_data;
                    hv2d_pkg::RegRefY: ref_y_reg <= cfg_data;
                    hv2d_pkg::RegSort: sort_reg  <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        key_reg      <= key_next;
        prev_reg     <= prev_next;
        w_reg        <= w_next;
        dy_reg       <= dy_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        vol_reg      <= vol_next;
        pc_reg       <= pc_next;
        sat_reg      <= sat_next;
        drop_reg     <= drop_next;
        res_vol_reg  <= res_vol_next;
        res_pc_reg   <= res_pc_next;
        res_sat_reg  <= res_sat_next;
        res_drop_reg <= res_drop_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        i_next = i_reg;
        j_next = j_reg;
        key_next = key_reg;
        prev_next = prev_reg;
        w_next = w_reg;
        dy_next = dy_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        vol_next = vol_reg;
        pc_next = pc_reg;
        sat_next = sat_reg;
        drop_next = drop_reg;
        res_vol_next = res_vol_reg;
        res_pc_next = res_pc_reg;
        res_sat_next = res_sat_reg;
        res_drop_next = res_drop_reg;
        ram_we = 1'b0;
        ram_addr = i_reg[AW-1:0];
        ram_wdata = key_reg;

        unique case (state_reg)
            hv2d_pkg::ST_LOAD:
            begin
                ram_addr = cnt_reg[AW-1:0];
                ram_wdata = {point_y ^ 32'h8000_0000, point_x};
                if (in_xfer)
                begin
                    if (point_present)
                    begin
                        if (cnt_reg < CW'(hv2d_pkg::MaxPoints))
                        begin
                            ram_we = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (last_item)
                    begin
                        drop_next = ovf_next;
                        pc_next = cnt_next;
                        acc_next = '0;
                        i_next = CW'(1);
                        state_next = sort_reg ? hv2d_pkg::ST_SORT_RD : hv2d_pkg::ST_SW_RD;
                        if (!sort_reg)
                        begin
                            i_next = '0;
                        end
                    end
                end
            end
            // Insertion sort: key_reg holds the element moving left, j the hole.
            hv2d_pkg::ST_SORT_RD:
            begin
                if (i_reg >= pc_reg)
                begin
                    i_next = '0;
                    state_next = hv2d_pkg::ST_SW_RD;
                end
                else
                begin
                    ram_addr = i_reg[AW-1:0];
                    j_next = i_reg;
                    prev_next = '1;          // marks "fetching key"
                    state_next = hv2d_pkg::ST_SORT_WAIT;
                end
            end
            hv2d_pkg::ST_SORT_WAIT:
            begin
                ram_addr = AW'(j_reg - 1'b1);
                if (prev_reg[0])
                begin
                    key_next = ram_rdata;
                    prev_next = '0;
                    state_next = hv2d_pkg::ST_SORT_WAIT;
                end
                else
                begin
                    state_next = hv2d_pkg::ST_SORT_CMP;
                end
            end
            hv2d_pkg::ST_SORT_CMP:
            begin
                ram_addr = j_reg[AW-1:0];
                if (ram_rdata[63:32] > key_reg[63:32])
                begin
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata;
                    j_next = j_reg - 1'b1;
                    state_next = (j_next == '0) ? hv2d_pkg::ST_SORT_WR
                                                : hv2d_pkg::ST_SORT_WAIT;
                end
                else
                begin
                    state_next = hv2d_pkg::ST_SORT_WR;
                end
            end
            hv2d_pkg::ST_SORT_WR:
            begin
                ram_addr = j_reg[AW-1:0];
                ram_we = 1'b1;
                ram_wdata = key_reg;
                i_next = i_reg + 1'b1;
                state_next = hv2d_pkg::ST_SORT_RD;
            end
            hv2d_pkg::ST_SW_RD:
            begin
                ram_addr = i_reg[AW-1:0];
                if (pc_reg == '0)
                begin
                    vol_next = '0;
                    sat_next = 1'b0;
                    state_next = hv2d_pkg::ST_DONE;
                end
                else if (i_reg >= pc_reg)
                begin
                    dy_next = 34'(signed'(ref_y_reg)) - ky(prev_reg);
                    state_next = hv2d_pkg::ST_LAST_MUL;
                end
                else
                begin
                    state_next = hv2d_pkg::ST_SW_WAIT;
                end
            end
            hv2d_pkg::ST_SW_WAIT:
            begin
                key_next = ram_rdata;
                if (i_reg == '0)
                begin
                    w_next = dx(ref_x_reg, ram_rdata);
                    prev_next = ram_rdata;
                    i_next = i_reg + 1'b1;
                    state_next = hv2d_pkg::ST_SW_RD;
                end
                else
                begin
                    dy_next = ky(ram_rdata) - ky(prev_reg);
                    state_next = hv2d_pkg::ST_SW_MUL;
                end
            end
            hv2d_pkg::ST_SW_MUL:
            begin
                prod_next = dy_reg * w_reg;
                state_next = hv2d_pkg::ST_SW_ACC;
            end
            hv2d_pkg::ST_SW_ACC:
            begin
                acc_next = acc_reg + 80'(prod_reg);
                if (dx(ref_x_reg, key_reg) > w_reg)
                begin
                    w_next = dx(ref_x_reg, key_reg);
                end
                prev_next = key_reg;
                i_next = i_reg + 1'b1;
                state_next = hv2d_pkg::ST_SW_RD;
            end
            hv2d_pkg::ST_LAST_MUL:
            begin
                prod_next = dy_reg * w_reg;
                state_next = hv2d_pkg::ST_LAST_ACC;
            end
            hv2d_pkg::ST_LAST_ACC:
            begin
                acc_next = acc_reg + 80'(prod_reg);
                if (acc_next[79:63] == '0 || acc_next[79:63] == '1)
                begin
                    vol_next = acc_next[63:0];
                    sat_next = 1'b0;
                end
                else
                begin
                    sat_next = 1'b1;
                    vol_next = acc_next[79] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
                end
                state_next = hv2d_pkg::ST_DONE;
            end
            hv2d_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    res_vol_next = vol_reg;
                    res_pc_next = pc_reg;
                    res_sat_next = sat_reg;
                    res_drop_next = drop_reg;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    state_next = hv2d_pkg::ST_LOAD;
                end
            end
            default: state_next = hv2d_pkg::ST_LOAD;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign volume      = res_vol_reg;
    assign point_count = res_pc_reg;
    assign saturated   = res_sat_reg;
    assign dropped     = res_drop_reg;
endmodule
